@@ hw/rtl/sha512_pkg.sv @@
// sha-512 package: round constants, initial hash, sequencer codes and round helpers
// used by sha512_round and sha512_hash_engine; no dependencies
`default_nettype none
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BlkWords = 16;

  // sequencer states of the top level
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COMP  = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // what to do after a compression completes
  localparam logic [1:0] AFTER_NONE = 2'd0;
  localparam logic [1:0] AFTER_PAD  = 2'd1;
  localparam logic [1:0] AFTER_LEN  = 2'd2;
  localparam logic [1:0] AFTER_OUT  = 2'd3;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [6:0]  SpillPos  = 7'd112;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 64'h6a09e667f3bcc908;
      3'd1: init_hash = 64'hbb67ae8584caa73b;
      3'd2: init_hash = 64'h3c6ef372fe94f82b;
      3'd3: init_hash = 64'ha54ff53a5f1d36f1;
      3'd4: init_hash = 64'h510e527fade682d1;
      3'd5: init_hash = 64'h9b05688c2b3e6c1f;
      3'd6: init_hash = 64'h1f83d9abfb41bd6b;
      default: init_hash = 64'h5be0cd19137e2179;
    endcase
  endfunction

  function automatic word_t round_k(input logic [6:0] r);
    case (r)
      7'd0: round_k = 64'h428a2f98d728ae22; 7'd1: round_k = 64'h7137449123ef65cd;
      7'd2: round_k = 64'hb5c0fbcfec4d3b2f; 7'd3: round_k = 64'he9b5dba58189dbbc;
      7'd4: round_k = 64'h3956c25bf348b538; 7'd5: round_k = 64'h59f111f1b605d019;
      7'd6: round_k = 64'h923f82a4af194f9b; 7'd7: round_k = 64'hab1c5ed5da6d8118;
      7'd8: round_k = 64'hd807aa98a3030242; 7'd9: round_k = 64'h12835b0145706fbe;
      7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
      7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
      7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
      7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
      7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
      7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
      7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
      7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
      7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
      7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
      7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
      7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
      7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
      7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
      7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
      7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
      7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
      7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
      7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
      7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
      7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
      7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
      7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
      7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
      7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
      7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
      7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
      7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
      7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
      7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
      7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
      7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
      7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
      7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
      7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
      default: round_k = 64'h0;
    endcase
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  // start and done handshake between the sequencer and the round unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/sha512_round.sv @@
// sha-512 compression unit: one round per cycle for all 80 rounds, rolling schedule
// depends on sha512_pkg
`default_nettype none
module sha512_round
  import sha512_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  word_t            blk [BlkWords],
  input  word_t            hin [8],
  output word_t            hout [8],
  output comp_ctl_t        ctl
);

  word_t       w [BlkWords];
  word_t       v [8];
  logic [6:0]  rnd;
  logic        busy;
  logic        done;

  word_t w2, w15, s0, s1, wr, t1, t2, ch, maj, e1, e0;

  // schedule word and round arithmetic for the current round
  always_comb begin
    w2  = w[4'(rnd - 7'd2)];
    w15 = w[4'(rnd - 7'd15)];
    s1  = ror(w2, 19) ^ ror(w2, 61) ^ (w2 >> 6);
    s0  = ror(w15, 1) ^ ror(w15, 8) ^ (w15 >> 7);
    if (rnd < 7'd16) begin
      wr = w[rnd[3:0]];
    end else begin
      wr = s1 + w[4'(rnd - 7'd7)] + s0 + w[rnd[3:0]];
    end
    e1  = ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + e1 + ch + round_k(rnd) + wr;
    e0  = ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = e0 + maj;
  end

  // round counter and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rnd  <= 7'd0;
      end else if (busy) begin
        if (rnd == 7'(Rounds - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        rnd <= rnd + 7'd1;
      end
    end
  end

  // working variables and schedule
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      for (int i = 0; i < BlkWords; i++) w[i] <= blk[i];
      for (int i = 0; i < 8; i++) v[i] <= hin[i];
    end else if (busy) begin
      w[rnd[3:0]] <= wr;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  // feed-forward sum is valid while done is high
  always_comb begin
    for (int i = 0; i < 8; i++) hout[i] = hin[i] + v[i];
    ctl.start = start;
    ctl.busy  = busy;
    ctl.done  = done;
  end

endmodule
`default_nettype wire

@@ hw/rtl/sha512_hash_engine.sv @@
// a non-last word is taken in ST_IDLE; a word that fills a block then starts a compression
// a last word goes through padding (ST_PAD) and length setup (ST_LEN), with a compression
// of each finished block (one or two), then 8 output beats
// throughput is set by the single round unit: no new word is taken while a block is compressed
// rst (synchronous) restores the initial hash and clears the byte count and sequencer
// top level of the sha-512 engine; depends on sha512_pkg and sha512_round
`default_nettype none
module sha512_hash_engine
  import sha512_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // message_word[63:0], valid_bytes[67:64], zeros
  input  wire logic        s_tlast,   // last_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // digest_word[63:0]
  output logic [2:0]       m_tuser,   // digest_index
  output logic             m_tlast    // digest_last
);

  word_t       hv [8];
  word_t       blk [BlkWords];
  word_t       hout [8];
  logic [63:0] len_lo;
  logic [63:0] len_hi;
  logic [2:0]  state;
  logic [1:0]  after;
  logic        cstart;
  logic [2:0]  oidx;
  comp_ctl_t   cc;

  sha512_round u_round (
    .clk(clk), .rst(rst), .start(cstart), .blk(blk), .hin(hv), .hout(hout), .ctl(cc)
  );

  logic        acc;
  logic [3:0]  nb;
  logic [63:0] mask;
  logic [3:0]  idx;
  logic [63:0] add_n;
  logic [64:0] lo_sum;
  logic [6:0]  p;

  always_comb begin
    s_tready = (state == ST_IDLE) && !cstart;
    acc   = s_tvalid && s_tready;
    nb    = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
    mask  = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb, 3'b000});
    idx   = len_lo[6:3];
    add_n = s_tlast ? {60'd0, nb} : 64'd8;
    lo_sum = {1'b0, len_lo} + {1'b0, add_n};
    p     = len_lo[6:0];
    m_tvalid = (state == ST_OUT);
    m_tdata  = hv[oidx];
    m_tuser  = oidx;
    m_tlast  = (oidx == 3'd7);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      after  <= AFTER_NONE;
      cstart <= 1'b0;
      oidx   <= 3'd0;
      len_lo <= 64'd0;
      len_hi <= 64'd0;
      for (int i = 0; i < 8; i++) hv[i] <= init_hash(3'(i));
    end else begin
      cstart <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            blk[idx] <= s_tlast ? (s_tdata[63:0] & mask) : s_tdata[63:0];
            len_lo <= lo_sum[63:0];
            len_hi <= len_hi + {63'd0, lo_sum[64]};
            if (!s_tlast) begin
              if (idx == 4'd15) begin
                cstart <= 1'b1; after <= AFTER_NONE; state <= ST_COMP;
              end
            end else if (lo_sum[6:0] == 7'd0 && nb == 4'd8 && idx == 4'd15) begin
              cstart <= 1'b1; after <= AFTER_PAD; state <= ST_COMP;
            end else begin
              state <= ST_PAD;
            end
          end
        end
        ST_COMP: begin
          if (cc.done) begin
            for (int i = 0; i < 8; i++) hv[i] <= hout[i];
            case (after)
              AFTER_PAD: state <= ST_PAD;
              AFTER_LEN: begin
                for (int i = 0; i < BlkWords; i++) blk[i] <= 64'd0;
                state <= ST_LEN;
              end
              AFTER_OUT: begin
                oidx <= 3'd0; state <= ST_OUT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_PAD: begin
          // 0x80 marker after the last byte, zeros above
          for (int i = 0; i < BlkWords; i++) begin
            if (4'(i) > p[6:3]) blk[i] <= 64'd0;
          end
          if (p[2:0] == 3'd0) begin
            blk[p[6:3]] <= {PadByte, 56'd0};
          end else begin
            blk[p[6:3]] <= blk[p[6:3]] | ({56'd0, PadByte} << (7'd56 - {1'b0, p[2:0], 3'b000}));
          end
          if (p >= SpillPos) begin
            cstart <= 1'b1; after <= AFTER_LEN; state <= ST_COMP;
          end else begin
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          blk[14] <= {len_hi[60:0], len_lo[63:61]};
          blk[15] <= {len_lo[60:0], 3'b000};
          cstart <= 1'b1; after <= AFTER_OUT; state <= ST_COMP;
        end
        ST_OUT: begin
          if (m_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) hv[i] <= init_hash(3'(i));
              len_lo <= 64'd0;
              len_hi <= 64'd0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/sha512_chk.sv @@
// port-level checker for sha512_hash_engine, attached with bind
// depends on sha512_pkg only through the bound top level
`default_nettype none
module sha512_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  // no input taken while digest is being sent
  a_excl: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready during digest output");

  // last flag marks index seven
  a_last: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
    else $error("digest_last mismatch");

  // index steps by one after each transaction inside a digest
  a_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
    else $error("digest index skipped");

  // a stalled digest word keeps its index
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
    else $error("stalled digest changed");

endmodule

bind sha512_hash_engine sha512_chk u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

@@ verif/sha512_hash_engine_test.sv @@
// self-checking testbench for sha512_hash_engine: streams messages word by word and
// checks every digest word against an internal sha-512 predictor; depends on sha512_pkg
`default_nettype none
module sha512_hash_engine_test;
  import sha512_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // message_word[63:0], valid_bytes[67:64], zeros
  logic        s_tlast = 1'b0; // last_word
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // digest_word
  logic [2:0]  m_tuser;        // digest_index
  logic        m_tlast;        // digest_last

  sha512_hash_engine dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // predictor state
  word_t        chain_hash [8];
  word_t        block_words [16];
  logic [127:0] byte_count;
  digest_beat_t digest_queue [$];

  int unsigned  fail_count;
  int unsigned  sent_words;
  int unsigned  messages_done;
  int unsigned  beats_checked;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  longint unsigned cycle_count;

  localparam longint unsigned CycleLimit = 64'd2_000_000;

  function automatic word_t rot(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t k_const(input int unsigned r);
    word_t k [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k[r];
  endfunction

  function automatic word_t start_word(input int unsigned i);
    word_t h [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    return h[i];
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_hash[i] = start_word(i);
    byte_count = '0;
  endtask

  // one 80-round compression of block_words into chain_hash
  task automatic compress_into_chain();
    word_t w [16];
    word_t v [8];
    word_t wr, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        s1 = rot(w[(r-2)&15], 19) ^ rot(w[(r-2)&15], 61) ^ (w[(r-2)&15] >> 6);
        s0 = rot(w[(r-15)&15], 1) ^ rot(w[(r-15)&15], 8) ^ (w[(r-15)&15] >> 7);
        wr = s1 + w[(r-7)&15] + s0 + w[r&15];
        w[r&15] = wr;
      end
      t1 = v[7] + (rot(v[4], 14) ^ rot(v[4], 18) ^ rot(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + wr;
      t2 = (rot(v[0], 28) ^ rot(v[0], 34) ^ rot(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
  endtask

  // absorb one accepted word; on a last word pad, finish and queue the digest
  task automatic absorb_word(input word_t word, input logic [3:0] nbytes_in, input logic fin);
    int unsigned slot, p, pw, nb;
    word_t mask;
    logic [127:0] bits;
    slot = byte_count[6:3];
    if (!fin) begin
      block_words[slot] = word;
      byte_count += 8;
      if (slot == 15) compress_into_chain();
      return;
    end
    nb = (nbytes_in > 8) ? 8 : nbytes_in;
    mask = (nb == 0) ? '0 : ~64'h0 << (64 - 8 * nb);
    block_words[slot] = word & mask;
    byte_count += nb;
    p = byte_count[6:0];
    if (p == 0 && nb == 8 && slot == 15) compress_into_chain();
    pw = p >> 3;
    if ((p & 7) == 0) block_words[pw] = '0;
    block_words[pw] |= 64'h80 << (56 - 8 * (p & 7));
    for (int i = pw + 1; i < 16; i++) block_words[i] = '0;
    if (p >= 112) begin
      compress_into_chain();
      for (int i = 0; i < 16; i++) block_words[i] = '0;
    end
    bits = byte_count << 3;
    block_words[14] = bits[127:64];
    block_words[15] = bits[63:0];
    compress_into_chain();
    for (int i = 0; i < 8; i++)
      digest_queue.push_back('{chain_hash[i], 3'(i), logic'(i == 7)});
    restart_hash();
  endtask

  // drive one transaction and wait for its acceptance; valid stays high after it
  task automatic send_word(input word_t word, input logic [3:0] nbytes, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, nbytes, word};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    absorb_word(word, nbytes, fin);
    sent_words++;
    if (fin) messages_done++;
  endtask

  // message of n full words then a last word with nb valid bytes
  task automatic send_message(input int unsigned n, input logic [3:0] nb);
    for (int i = 0; i < n; i++) send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
    send_word({$urandom, $urandom}, nb, 1'b1);
  endtask

  task automatic drain_digests();
    s_tvalid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // known-answer inputs, byte counts around the spill point, zero and oversize valid bytes
  task automatic test_directed();
    send_word(64'h6162630000000000, 4'd3, 1'b1);   // "abc"
    send_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b1); // empty message
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
    send_word(64'h0, 4'd15, 1'b1);
    send_message(13, 4'd7);  // 111 bytes, no spill
    send_message(13, 4'd8);  // 112 bytes, spills
    send_message(15, 4'd0);  // 120 bytes, spills
    send_message(15, 4'd8);  // 128 bytes
    send_message(14, 4'd1);
    drain_digests();
  endtask

  task automatic test_random(input int unsigned words, input int unsigned idle,
                             input int unsigned stall);
    int unsigned target, n;
    logic [3:0] nb;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    target = sent_words + words;
    while (sent_words < target) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(20);
      nb = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      send_message(n, nb);
    end
    drain_digests();
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare every accepted digest beat with the oldest expectation
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      beats_checked <= beats_checked + 1;
      if (digest_queue.size() == 0) begin
        $error("digest transaction with none expected: %h", m_tdata);
        fail_count++;
      end else begin
        exp_beat = digest_queue.pop_front();
        if (m_tdata !== exp_beat.word) begin
          $error("digest_word expected %h got %h", exp_beat.word, m_tdata);
          fail_count++;
        end
        if (m_tuser !== exp_beat.index) begin
          $error("digest_index expected %0d got %0d", exp_beat.index, m_tuser);
          fail_count++;
        end
        if (m_tlast !== exp_beat.last) begin
          $error("digest_last expected %0d got %0d", exp_beat.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sha512_hash_engine");
      $finish;
    end
  end

  initial begin
    fail_count = 0; sent_words = 0; messages_done = 0; beats_checked = 0;
    send_idle_pct = 0; recv_stall_pct = 0; cycle_count = 0;
    restart_hash();
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(60, 0, 0);
    test_random(60, 66, 0);
    test_random(60, 0, 66);
    test_random(60, 24, 24);
    if (digest_queue.size() != 0) begin
      $error("%0d digest words never arrived", digest_queue.size());
      fail_count++;
    end
    $display("sent %0d words in %0d messages, checked %0d digest words",
             sent_words, messages_done, beats_checked);
    $display("covered spill and block-edge padding, zero and oversize byte counts, stalls");
    if (fail_count == 0) begin
      $display("PASS sha512_hash_engine");
    end else begin
      $display("FAIL sha512_hash_engine");
    end
    $finish;
  end

endmodule
`default_nettype wire
